@@ sv/assert_macros.svh @@
// Assertion helpers included by the blend RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ sv/pgtb_pkg.sv @@
`default_nettype none

package pgtb_pkg;

    // Blend modes
    typedef enum logic [1:0] {
        MODE_GRADIENT = 2'd0,
        MODE_FULL     = 2'd1,
        MODE_SHARP    = 2'd2,
        MODE_ADD      = 2'd3
    } mode_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_MODE           = 3'd0,
        REG_FLIP           = 3'd1,
        REG_TARGET_RED     = 3'd2,
        REG_TARGET_GREEN   = 3'd3,
        REG_TARGET_BLUE    = 3'd4,
        REG_STRENGTH       = 3'd5,
        REG_INVERSE_WIDTH  = 3'd6,
        REG_INVERSE_HEIGHT = 3'd7
    } reg_index_t;

    localparam int FRACTION_BITS = 16;   // fraction bits of strength, weight and sizes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 17;
    localparam int PIX_W     = 8;
    localparam int TGT_W     = 9;
    localparam int DELTA_W   = 10;   // target minus component, signed
    localparam int MAG_W     = 9;    // magnitude of a delta
    localparam int GAIN_W    = 17;   // strength and blend gain
    localparam int INV_W     = 17;   // inverse frame sizes
    localparam int PROD_W    = MAG_W + GAIN_W;

    localparam logic [INV_W-1:0] INV_RESET = 17'd64;

endpackage

`default_nettype wire

@@ sv/pgtb_pull.sv @@
`default_nettype none

// One channel's pull: sign(delta) * ((|delta| * gain) >> FRACTION_BITS), registered
module pgtb_pull
    import pgtb_pkg::*;
(
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic signed [DELTA_W-1:0]           delta,
    input  wire logic        [GAIN_W-1:0]            gain,
    output logic signed      [PROD_W-FRACTION_BITS:0] pull
);

    localparam int Q_W = PROD_W - FRACTION_BITS;

    logic signed [DELTA_W-1:0] abs_delta;
    logic        [MAG_W-1:0]   mag;
    logic        [PROD_W-1:0]  prod;
    logic        [Q_W-1:0]     quot;
    logic signed [Q_W:0]       pull_next;
    logic signed [Q_W:0]       pull_reg;

    // Truncate toward zero by scaling the magnitude
    always_comb
    begin
        abs_delta = delta[DELTA_W-1] ? -delta : delta;
        mag       = abs_delta[MAG_W-1:0];
        prod      = PROD_W'(mag) * PROD_W'(gain);
        quot      = prod[PROD_W-1:FRACTION_BITS];
        pull_next = delta[DELTA_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end

    // Advance with the stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pull_reg <= pull_next;
        end
    end

    assign pull = pull_reg;

endmodule

`default_nettype wire

@@ sv/pixel_gradient_tint_blend.sv @@
// Recolors one RGB pixel per beat. Each input beat carries column, row and the
// three 8-bit components; each output beat carries the recolored, saturated
// components. Gradient mode pulls each component toward the target by
// delta * strength * w^3 with w = 0.4*row/H + 0.6*column/W (or 1 - w when flip
// is set), full mode by delta * strength, sharp mode adds the smallest pull
// to all components, add mode adds the target. A black pixel passes unchanged
// in the blend modes. Throughput is one pixel per clock while the output is
// ready, through an eight-stage pipeline (two multiplies for the weight, one
// stage to sum, clamp and flip, two for the cube, one for the gain, one for
// the pull, then min and saturate). Each stage holds its beat on a stall and
// a bubble in any stage is filled, so the input keeps accepting while any
// stage is empty. Write configuration only while the pipeline is empty.
`default_nettype none

`include "assert_macros.svh"

module pixel_gradient_tint_blend
    import pgtb_pkg::*;
#(
    parameter int COORD_BITS    = 12
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // configuration write port
    input  wire logic                    cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    // input pixels
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata: column, row, in_red, in_green, in_blue (lowest bit up), zero pad
    input  wire logic [((2*COORD_BITS+3*PIX_W+7)/8)*8-1:0] s_axis_tdata,
    // output pixels
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // tdata: out_red, out_green, out_blue (lowest bit up)
    output logic [3*PIX_W-1:0]           m_axis_tdata
);

    localparam int NSTAGE  = 8;
    localparam int W_W     = FRACTION_BITS + 1;
    localparam int PH_W    = COORD_BITS + INV_W;
    localparam int SH_W    = PH_W + FRACTION_BITS;
    localparam int WQ_W    = PH_W + 1;
    localparam int SQ_W    = 2 * W_W;
    localparam int GP_W    = GAIN_W + W_W;
    localparam int D_W     = PROD_W - FRACTION_BITS + 1;
    localparam int SUM_W   = D_W + 11;
    localparam logic [W_W-1:0] ONE_Q = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [FRACTION_BITS-1:0] K04 =
        FRACTION_BITS'(((64'd4 << FRACTION_BITS) + 64'd5) / 64'd10);
    localparam logic [FRACTION_BITS-1:0] K06 =
        FRACTION_BITS'(((64'd6 << FRACTION_BITS) + 64'd5) / 64'd10);

    // Configuration registers
    mode_t              mode_reg;
    logic               flip_reg;
    logic [TGT_W-1:0]   tgt_reg [3];
    logic [GAIN_W-1:0]  strength_reg;
    logic [INV_W-1:0]   inv_w_reg;
    logic [INV_W-1:0]   inv_h_reg;

    // Pipeline control
    logic [NSTAGE-1:0]  vld_reg;
    logic [NSTAGE-1:0]  en;

    // Pixel side band carried through the pipe
    logic [PIX_W-1:0]          pix_reg   [7][3];
    logic signed [DELTA_W-1:0] delta_reg [6][3];
    logic [6:0]                zero_reg;

    // Weight and gain datapath
    logic [PH_W-1:0]    ph_reg, pw_reg;
    logic [SH_W-1:0]    sh_reg, sw_reg;
    logic [W_W-1:0]     w_reg, w3in_reg, w2_reg, w3_reg;
    logic [GAIN_W-1:0]  gain_reg;

    logic [PH_W-1:0]    ph_next, pw_next;
    logic [SH_W-1:0]    sh_next, sw_next;
    logic [SH_W:0]      wsum;
    logic [WQ_W-1:0]    wq;
    logic [W_W-1:0]     wsat, w_next;
    logic [SQ_W-1:0]    sq, cu;
    logic [GP_W-1:0]    gp;
    logic [GAIN_W-1:0]  gain_next;

    logic [PIX_W-1:0]          in_pix   [3];
    logic signed [DELTA_W-1:0] in_delta [3];
    logic signed [D_W-1:0]     pull     [3];
    logic signed [SUM_W-1:0]   adj      [3];
    logic signed [SUM_W-1:0]   sum      [3];
    logic signed [D_W-1:0]     pull_min;
    logic [3*PIX_W-1:0]        out_next;
    logic [3*PIX_W-1:0]        out_reg;

    function automatic logic [PIX_W-1:0] sat8(input logic signed [SUM_W-1:0] v);
        logic [PIX_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > SUM_W'(255))
        begin
            r = '1;
        end
        else
        begin
            r = v[PIX_W-1:0];
        end
        return r;
    endfunction

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_GRADIENT;
            flip_reg     <= 1'b0;
            tgt_reg[0]   <= '0;
            tgt_reg[1]   <= '0;
            tgt_reg[2]   <= '0;
            strength_reg <= '0;
            inv_w_reg    <= INV_RESET;
            inv_h_reg    <= INV_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_MODE:           mode_reg     <= mode_t'(cfg_data[1:0]);
                REG_FLIP:           flip_reg     <= cfg_data[0];
                REG_TARGET_RED:     tgt_reg[0]   <= cfg_data[TGT_W-1:0];
                REG_TARGET_GREEN:   tgt_reg[1]   <= cfg_data[TGT_W-1:0];
                REG_TARGET_BLUE:    tgt_reg[2]   <= cfg_data[TGT_W-1:0];
                REG_STRENGTH:       strength_reg <= cfg_data[GAIN_W-1:0];
                REG_INVERSE_WIDTH:  inv_w_reg    <= cfg_data[INV_W-1:0];
                REG_INVERSE_HEIGHT: inv_h_reg    <= cfg_data[INV_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage enables: a stage moves when it is empty or the next one moves
    always_comb
    begin
        en[NSTAGE-1] = !vld_reg[NSTAGE-1] || m_axis_tready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[0];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 0: unpack, coordinate products, deltas
    always_comb
    begin
        in_pix[0] = s_axis_tdata[2*COORD_BITS +: PIX_W];
        in_pix[1] = s_axis_tdata[2*COORD_BITS+PIX_W +: PIX_W];
        in_pix[2] = s_axis_tdata[2*COORD_BITS+2*PIX_W +: PIX_W];
        for (int i = 0; i < 3; i++)
        begin
            in_delta[i] = $signed({tgt_reg[i][TGT_W-1], tgt_reg[i]})
                        - $signed({2'b00, in_pix[i]});
        end
        pw_next = PH_W'(s_axis_tdata[COORD_BITS-1:0]) * PH_W'(inv_w_reg);
        ph_next = PH_W'(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]) * PH_W'(inv_h_reg);
    end

    // Stage 1: scale by the 0.4 and 0.6 weights
    always_comb
    begin
        sh_next = SH_W'(ph_reg) * SH_W'(K04);
        sw_next = SH_W'(pw_reg) * SH_W'(K06);
    end

    // Stage 2: sum, drop fraction, clamp to one, flip
    always_comb
    begin
        wsum = {1'b0, sh_reg} + {1'b0, sw_reg};
        wq   = wsum[SH_W:FRACTION_BITS];
        wsat = (wq > WQ_W'(ONE_Q)) ? ONE_Q : wq[W_W-1:0];
        w_next = flip_reg ? (ONE_Q - wsat) : wsat;
    end

    // Stages 3 to 5: square, cube, gain
    always_comb
    begin
        sq = SQ_W'(w_reg) * SQ_W'(w_reg);
        cu = SQ_W'(w2_reg) * SQ_W'(w3in_reg);
        gp = GP_W'(strength_reg) * GP_W'(w3_reg);
        gain_next = (mode_reg == MODE_GRADIENT) ? gp[FRACTION_BITS +: GAIN_W]
                                                : strength_reg;
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ph_reg      <= ph_next;
            pw_reg      <= pw_next;
            zero_reg[0] <= (in_pix[0] == '0) && (in_pix[1] == '0) && (in_pix[2] == '0);
            for (int i = 0; i < 3; i++)
            begin
                pix_reg[0][i]   <= in_pix[i];
                delta_reg[0][i] <= in_delta[i];
            end
        end
        if (en[1])
        begin
            sh_reg <= sh_next;
            sw_reg <= sw_next;
        end
        if (en[2])
        begin
            w_reg <= w_next;
        end
        if (en[3])
        begin
            w2_reg   <= sq[FRACTION_BITS +: W_W];
            w3in_reg <= w_reg;
        end
        if (en[4])
        begin
            w3_reg <= cu[FRACTION_BITS +: W_W];
        end
        if (en[5])
        begin
            gain_reg <= gain_next;
        end
        for (int k = 1; k < 7; k++)
        begin
            if (en[k])
            begin
                zero_reg[k] <= zero_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    pix_reg[k][i] <= pix_reg[k-1][i];
                end
            end
        end
        for (int k = 1; k < 6; k++)
        begin
            if (en[k])
            begin
                for (int i = 0; i < 3; i++)
                begin
                    delta_reg[k][i] <= delta_reg[k-1][i];
                end
            end
        end
        if (en[7])
        begin
            out_reg <= out_next;
        end
    end

    // Stage 6: per-channel pulls
    for (genvar g = 0; g < 3; g++)
    begin : g_pull
        pgtb_pull u_pull (
            .clk   (clk),
            .en    (en[6]),
            .delta (delta_reg[5][g]),
            .gain  (gain_reg),
            .pull  (pull[g])
        );
    end

    // Stage 7: select adjustment, add and saturate
    always_comb
    begin
        pull_min = pull[0];
        if (pull[1] < pull_min)
        begin
            pull_min = pull[1];
        end
        if (pull[2] < pull_min)
        begin
            pull_min = pull[2];
        end
        for (int i = 0; i < 3; i++)
        begin
            if (mode_reg == MODE_ADD)
            begin
                adj[i] = {{(SUM_W-TGT_W){tgt_reg[i][TGT_W-1]}}, tgt_reg[i]};
            end
            else if (zero_reg[6])
            begin
                adj[i] = '0;
            end
            else if (mode_reg == MODE_SHARP)
            begin
                adj[i] = {{(SUM_W-D_W){pull_min[D_W-1]}}, pull_min};
            end
            else
            begin
                adj[i] = {{(SUM_W-D_W){pull[i][D_W-1]}}, pull[i]};
            end
            sum[i] = $signed({{(SUM_W-PIX_W){1'b0}}, pix_reg[6][i]}) + adj[i];
        end
        out_next = {sat8(sum[2]), sat8(sum[1]), sat8(sum[0])};
    end

    assign m_axis_tvalid = vld_reg[NSTAGE-1];
    assign m_axis_tdata  = out_reg;

    // Checks
    `ASSERT_IMPLY(a_ready_on_bubble, clk, rst_n, !(&vld_reg), s_axis_tready)
    `ASSERT_NEXT(a_pull_stage_holds, clk, rst_n, vld_reg[6] && !en[6], vld_reg[6])
    `ASSERT_IMPLY(a_weight_bound, clk, rst_n, vld_reg[2], w_reg <= ONE_Q)
    `ASSERT_IMPLY(a_gain_bound, clk, rst_n, vld_reg[5], gain_reg <= strength_reg)

endmodule

`default_nettype wire

@@ dv/pixel_gradient_tint_blend_checker.sv @@
module pixel_gradient_tint_blend_checker
    import pgtb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wen,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 s_axis_tvalid,
    input  wire logic                 s_axis_tready,
    // tdata: column, row, in_red, in_green, in_blue (lowest bit up)
    input  wire logic [47:0]          s_axis_tdata,
    input  wire logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // tdata: out_red, out_green, out_blue (lowest bit up)
    input  wire logic [23:0]          m_axis_tdata,
    output int                        pending,
    output int                        fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC  = 16;
    localparam longint UNITY = longint'(1) << FRAC;
    localparam longint K04   = ((longint'(4) << FRAC) + 5) / 10;
    localparam longint K06   = ((longint'(6) << FRAC) + 5) / 10;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [11:0] row;
        logic [11:0] column;
    } pixel_beat_t;

    // shadow copy of the register file
    mode_t                   blend_mode;
    logic                    flip_weight;
    logic signed [TGT_W-1:0] tint [3];
    logic [GAIN_W-1:0]       strength_q;
    logic [INV_W-1:0]        inv_width;
    logic [INV_W-1:0]        inv_height;

    rgb_t expected_pixels [$];
    int   errors = 0;

    // truncate toward zero: sign(delta) * ((|delta| * gain) >> FRAC)
    function automatic int pull_toward(int delta, longint gain);
        longint mag;
        longint r;
        mag = (delta < 0) ? -delta : delta;
        r = (mag * gain) >> FRAC;
        return (delta < 0) ? -int'(r) : int'(r);
    endfunction

    function automatic logic [7:0] clamp_byte(int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    function automatic rgb_t recolor(pixel_beat_t px);
        longint wgt;
        longint w2;
        longint w3;
        longint gain;
        int     comp [3];
        int     tgt [3];
        int     shift [3];
        int     low;
        rgb_t   res;
        comp[0] = px.red;
        comp[1] = px.green;
        comp[2] = px.blue;
        for (int i = 0; i < 3; i++)
            tgt[i] = tint[i];
        if (blend_mode == MODE_ADD)
            shift = tgt;
        else if (px.red == 8'd0 && px.green == 8'd0 && px.blue == 8'd0)
            shift = '{0, 0, 0};
        else
        begin
            if (blend_mode == MODE_GRADIENT)
            begin
                // weight from position, clipped to one, then cubed
                wgt = (longint'(px.row) * inv_height * K04
                       + longint'(px.column) * inv_width * K06) >> FRAC;
                if (wgt > UNITY)
                    wgt = UNITY;
                if (flip_weight)
                    wgt = UNITY - wgt;
                w2 = (wgt * wgt) >> FRAC;
                w3 = (w2 * wgt) >> FRAC;
                gain = (longint'(strength_q) * w3) >> FRAC;
            end
            else
                gain = strength_q;
            for (int i = 0; i < 3; i++)
                shift[i] = pull_toward(tgt[i] - comp[i], gain);
            if (blend_mode == MODE_SHARP)
            begin
                low = shift[0];
                if (shift[1] < low)
                    low = shift[1];
                if (shift[2] < low)
                    low = shift[2];
                shift = '{low, low, low};
            end
        end
        res.red   = clamp_byte(comp[0] + shift[0]);
        res.green = clamp_byte(comp[1] + shift[1]);
        res.blue  = clamp_byte(comp[2] + shift[2]);
        return res;
    endfunction

    task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rgb_t got;
        rgb_t want;
        if (!rst_n)
        begin
            blend_mode  = MODE_GRADIENT;
            flip_weight = 1'b0;
            tint        = '{default: '0};
            strength_q  = '0;
            inv_width   = INV_RESET;
            inv_height  = INV_RESET;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            // track register writes
            if (cfg_wen)
            begin
                case (reg_index_t'(cfg_index))
                    REG_MODE:           blend_mode  = mode_t'(cfg_data[1:0]);
                    REG_FLIP:           flip_weight = cfg_data[0];
                    REG_TARGET_RED:     tint[0]     = cfg_data[TGT_W-1:0];
                    REG_TARGET_GREEN:   tint[1]     = cfg_data[TGT_W-1:0];
                    REG_TARGET_BLUE:    tint[2]     = cfg_data[TGT_W-1:0];
                    REG_STRENGTH:       strength_q  = cfg_data[GAIN_W-1:0];
                    REG_INVERSE_WIDTH:  inv_width   = cfg_data[INV_W-1:0];
                    REG_INVERSE_HEIGHT: inv_height  = cfg_data[INV_W-1:0];
                    default: ;
                endcase
            end
            // check an output beat against the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: output beat with nothing pending, expected none, got %h",
                             $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    compare_field("out_red", want.red, got.red);
                    compare_field("out_green", want.green, got.green);
                    compare_field("out_blue", want.blue, got.blue);
                end
            end
            // predict each accepted input beat
            if (s_axis_tvalid && s_axis_tready)
                expected_pixels.push_back(recolor(pixel_beat_t'(s_axis_tdata)));
            pending    <= expected_pixels.size();
            fail_count <= errors;
        end
    end

endmodule

@@ dv/pixel_gradient_tint_blend_tb.sv @@
module pixel_gradient_tint_blend_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pgtb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 12;
    localparam int PHASE_BEATS = 153;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_wen       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;

    int pending;
    int fail_count;
    int gap_pct = 22;
    int cycles  = 0;

    pixel_gradient_tint_blend uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pixel_gradient_tint_blend_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // random backpressure on the output side
    always @(posedge clk)
    begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= gap_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("pixel_gradient_tint_blend verification failed");
            $finish;
        end
    end

    // present one pixel, with random gaps, and hold it until accepted
    task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                              input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        while ($urandom_range(99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, g, r, row, col};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // drop valid and wait until every pixel has come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // write the whole register file, one register per cycle
    task automatic load_settings(input mode_t m, input logic fl, input int tr,
                                 input int tg, input int tb,
                                 input logic [16:0] str, input logic [16:0] iw,
                                 input logic [16:0] ih);
        logic [CFG_W-1:0] vals [8];
        reg_index_t       idx;
        vals[REG_MODE]           = {15'd0, m};
        vals[REG_FLIP]           = {16'd0, fl};
        vals[REG_TARGET_RED]     = {8'd0, 9'(tr)};
        vals[REG_TARGET_GREEN]   = {8'd0, 9'(tg)};
        vals[REG_TARGET_BLUE]    = {8'd0, 9'(tb)};
        vals[REG_STRENGTH]       = str;
        vals[REG_INVERSE_WIDTH]  = iw;
        vals[REG_INVERSE_HEIGHT] = ih;
        idx = REG_MODE;
        cfg_wen <= 1'b1;
        do
        begin
            cfg_index <= idx;
            cfg_data  <= vals[idx];
            @(posedge clk);
            idx = idx.next();
        end
        while (idx != REG_MODE);
        cfg_wen <= 1'b0;
    endtask

    function automatic int pick_target();
        case ($urandom_range(9))
            0:       return -256;
            1:       return 255;
            2:       return 0;
            default: return int'($urandom_range(511)) - 256;
        endcase
    endfunction

    // mostly plausible frame sizes, sometimes zero, tiny or out of range
    function automatic logic [16:0] pick_inverse();
        case ($urandom_range(9))
            0:       return 17'd0;
            1:       return 17'd1;
            2:       return 17'd65536;
            3:       return 17'd131071;
            4, 5:    return 17'($urandom_range(131071));
            default: return 17'(65536 >> $urandom_range(12, 4));
        endcase
    endfunction

    initial
    begin
        mode_t       m;
        logic        fl;
        int          tr;
        int          tg;
        int          tb;
        logic [16:0] str;
        logic [16:0] iw;
        logic [16:0] ih;
        int          span_x;
        int          span_y;
        int          pick;
        logic [11:0] col;
        logic [11:0] row;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: gradient with zero strength
        send_pixel(12'd100, 12'd200, 8'd10, 8'd20, 8'd30);
        send_pixel(12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF);
        settle();

        // gradient across a 4096 x 4096 frame, black pixel included
        load_settings(MODE_GRADIENT, 1'b0, 255, -256, 100, 17'd65536, 17'd16, 17'd16);
        send_pixel(12'd0, 12'd0, 8'd0, 8'd255, 8'd128);
        send_pixel(12'hFFF, 12'hFFF, 8'd0, 8'd255, 8'd128);
        send_pixel(12'd2048, 12'd1024, 8'd200, 8'd50, 8'd100);
        send_pixel(12'd100, 12'd100, 8'd0, 8'd0, 8'd0);
        settle();

        // flipped weight, zero inverse height, weight clipped above one
        load_settings(MODE_GRADIENT, 1'b1, -256, 255, 0, 17'd131071, 17'd65536, 17'd0);
        send_pixel(12'd0, 12'hFFF, 8'd128, 8'd64, 8'd32);
        send_pixel(12'd1, 12'd0, 8'd255, 8'd0, 8'd255);
        send_pixel(12'hFFF, 12'hFFF, 8'd1, 8'd2, 8'd3);
        settle();

        // full blend with strength above one, results saturate
        load_settings(MODE_FULL, 1'b0, -256, 255, -1, 17'd131071, 17'd64, 17'd64);
        send_pixel(12'd0, 12'd0, 8'd255, 8'd0, 8'd128);
        send_pixel(12'hFFF, 12'd0, 8'd1, 8'd254, 8'd0);
        send_pixel(12'd10, 12'd10, 8'd0, 8'd0, 8'd0);
        settle();

        // sharp minimum blend
        load_settings(MODE_SHARP, 1'b0, 200, 10, -50, 17'd32768, 17'd64, 17'd64);
        send_pixel(12'd5, 12'd5, 8'd100, 8'd100, 8'd100);
        send_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(12'd7, 12'd7, 8'd255, 8'd255, 8'd1);
        settle();

        // add color, black pixel still gets the addend
        load_settings(MODE_ADD, 1'b0, 255, -256, 7, 17'd0, 17'd64, 17'd64);
        send_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(12'hFFF, 12'hFFF, 8'd255, 8'd255, 8'd255);
        send_pixel(12'd1, 12'd2, 8'd128, 8'd3, 8'd250);
        settle();

        // random phases, each with its own settings
        for (int ph = 0; ph < PHASES; ph++)
        begin
            gap_pct = (ph >= 4 && ph < 7) ? 0 : 22;
            pick = $urandom_range(5);
            m  = (pick >= 4) ? MODE_GRADIENT : mode_t'(pick);
            fl = $urandom_range(1);
            tr = pick_target();
            tg = pick_target();
            tb = pick_target();
            case ($urandom_range(7))
                0:       str = 17'd0;
                1:       str = 17'd65536;
                2:       str = 17'd131071;
                3:       str = 17'($urandom_range(131071));
                default: str = 17'($urandom_range(65536));
            endcase
            iw = pick_inverse();
            ih = pick_inverse();
            load_settings(m, fl, tr, tg, tb, str, iw, ih);
            span_x = (iw == 0 || 65536 / iw > 4095) ? 4095 : 65536 / iw;
            span_y = (ih == 0 || 65536 / ih > 4095) ? 4095 : 65536 / ih;
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                // keep most pixels inside the frame
                col = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(span_x));
                row = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(span_y));
                case ($urandom_range(19))
                    0:       {r, g, b} = '0;
                    1:       {r, g, b} = '1;
                    default: {r, g, b} = 24'($urandom);
                endcase
                send_pixel(col, row, r, g, b);
            end
            settle();
        end

        // let any stray beat show up before the verdict
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("pixel_gradient_tint_blend verification clean");
        else
            $display("pixel_gradient_tint_blend verification failed");
        $finish;
    end

endmodule
